// ===== rtl/yuv_to_rgb565_converter_unit_macros.svh =====
// Assertion macros used by the merge module.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef YUV_TO_RGB565_CONVERTER_UNIT_MACROS_SVH
`define YUV_TO_RGB565_CONVERTER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define YRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define YRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/yrc_pkg.sv =====
package yrc_pkg;

    // Input layouts selected by the layout register.
    localparam logic FMT_UYVY  = 1'b0;
    localparam logic FMT_YUV32 = 1'b1;

    // Register index decoded from the APB word address.
    localparam logic REG_LAYOUT = 1'b0;

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam int unsigned PIX_W   = 16;
    localparam int unsigned SUM_W   = 11;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    // Status of the lane stage, handed to the merge stage.
    typedef struct packed {
        logic valid;
        logic fmt;
    } yrc_stage_t;

    // Saturate a signed channel sum to 0..255.
    function automatic logic [7:0] sat8(input sum_t x);
        logic [7:0] res;
        if (x < 0)
        begin
            res = 8'd0;
        end
        else if (x > sum_t'(255))
        begin
            res = 8'd255;
        end
        else
        begin
            res = x[7:0];
        end
        return res;
    endfunction

    function automatic pixel_t pack565(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

// ===== rtl/yuv_to_rgb565_converter_unit.sv =====
// Channel  | Handshake                 | Payload
// word     | word_valid / word_ready   | byte0, byte1, byte2, byte3
// pixel    | pixel_valid / pixel_ready | pixel_first, pixel_second, second_valid
// config   | APB, pready tied high     | paddr[2] picks the register, pwdata[0]
//
// One word can be taken every clock while the pixel side does not stall.
// The two converter lanes are registered, then the merge stage holds the output word.
// A stall on the pixel side holds both stages; word_ready drops only when both stages
// are full and pixel_ready is low.
// Reset clears the stage valid bits and sets the input layout to UYVY.
module yuv_to_rgb565_converter_unit
    import yrc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               word_valid,
    output logic               word_ready,
    input  logic [7:0]         byte0,
    input  logic [7:0]         byte1,
    input  logic [7:0]         byte2,
    input  logic [7:0]         byte3,
    output logic               pixel_valid,
    input  logic               pixel_ready,
    output pixel_t             pixel_first,
    output pixel_t             pixel_second,
    output logic               second_valid
);

    logic       fmt_reg;
    logic       fmt_next;
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic       s1_fmt_reg;
    logic       reg_sel;
    logic       advance;
    logic       accept;
    logic [7:0] y_a;
    logic [7:0] y_b;
    logic [7:0] u_in;
    logic [7:0] v_in;
    pixel_t     pixel_a;
    pixel_t     pixel_b;
    yrc_stage_t stage;

    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1];
    assign prdata  = (reg_sel == REG_LAYOUT) ? {{(PDATA_W-1){1'b0}}, fmt_reg} : '0;

    assign fmt_next = (psel && penable && pwrite && (reg_sel == REG_LAYOUT))
                      ? pwdata[0] : fmt_reg;

    assign word_ready    = !s1_valid_reg || advance;
    assign accept        = word_valid && word_ready;
    assign s1_valid_next = word_ready ? word_valid : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg      <= FMT_UYVY;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            fmt_reg      <= fmt_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_fmt_reg <= fmt_reg;
        end
    end

    // Byte roles depend on the layout; lane B only matters in UYVY.
    always_comb
    begin
        unique case (fmt_reg)
            FMT_UYVY:
            begin
                u_in = byte0;
                y_a  = byte1;
                v_in = byte2;
                y_b  = byte3;
            end
            default:
            begin
                v_in = byte0;
                u_in = byte1;
                y_a  = byte2;
                y_b  = byte3;
            end
        endcase
    end

    yrc_lane u_lane_a (
        .clk   (clk),
        .load  (accept),
        .y     (y_a),
        .u     (u_in),
        .v     (v_in),
        .pixel (pixel_a)
    );

    yrc_lane u_lane_b (
        .clk   (clk),
        .load  (accept),
        .y     (y_b),
        .u     (u_in),
        .v     (v_in),
        .pixel (pixel_b)
    );

    assign stage.valid = s1_valid_reg;
    assign stage.fmt   = s1_fmt_reg;

    yrc_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage        (stage),
        .pixel_a      (pixel_a),
        .pixel_b      (pixel_b),
        .ready        (pixel_ready),
        .advance      (advance),
        .valid        (pixel_valid),
        .pixel_first  (pixel_first),
        .pixel_second (pixel_second),
        .second_valid (second_valid)
    );

endmodule

// ===== rtl/yrc_lane.sv =====
module yrc_lane
    import yrc_pkg::*;
(
    input  logic       clk,
    input  logic       load,
    input  logic [7:0] y,
    input  logic [7:0] u,
    input  logic [7:0] v,
    output pixel_t     pixel
);

    logic signed [7:0] uc;
    logic signed [7:0] vc;
    sum_t ys;
    sum_t us;
    sum_t vs;
    sum_t r_sum;
    sum_t g_sum;
    sum_t b_sum;
    pixel_t pixel_reg;
    pixel_t pixel_next;

    // Subtracting 128 from an unsigned byte is an inversion of its top bit.
    assign uc = {~u[7], u[6:0]};
    assign vc = {~v[7], v[6:0]};
    assign ys = sum_t'({3'b000, y});
    assign us = sum_t'(uc);
    assign vs = sum_t'(vc);

    // Arithmetic shifts of the signed chroma round toward minus infinity.
    always_comb
    begin
        r_sum = ys + vs + (vs >>> 2) + (vs >>> 3) + (vs >>> 5);
        g_sum = ys - ((us >>> 2) + (us >>> 4) + (us >>> 5))
                   - ((vs >>> 1) + (vs >>> 3) + (vs >>> 4) + (vs >>> 5));
        b_sum = ys + us + (us >>> 1) + (us >>> 2) + (us >>> 6);
        pixel_next = pack565(sat8(r_sum), sat8(g_sum), sat8(b_sum));
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign pixel = pixel_reg;

endmodule

// ===== rtl/yrc_merge.sv =====
module yrc_merge
    import yrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  yrc_stage_t stage,
    input  pixel_t     pixel_a,
    input  pixel_t     pixel_b,
    input  logic       ready,
    output logic       advance,
    output logic       valid,
    output pixel_t     pixel_first,
    output pixel_t     pixel_second,
    output logic       second_valid
);

`include "yuv_to_rgb565_converter_unit_macros.svh"

    logic   valid_reg;
    logic   valid_next;
    pixel_t first_reg;
    pixel_t second_reg;
    logic   second_valid_reg;

    // The output register may take a new word when it is empty or being drained.
    assign advance    = !valid_reg || ready;
    assign valid_next = advance ? stage.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage.valid)
        begin
            first_reg        <= pixel_a;
            second_reg       <= (stage.fmt == FMT_UYVY) ? pixel_b : '0;
            second_valid_reg <= (stage.fmt == FMT_UYVY);
        end
    end

    assign valid        = valid_reg;
    assign pixel_first  = first_reg;
    assign pixel_second = second_reg;
    assign second_valid = second_valid_reg;

    `YRC_ASSERT_NOW(a_second_zero, valid_reg && !second_valid_reg, second_reg == '0, "second pixel not cleared in one-pixel mode")
    `YRC_ASSERT_NEXT(a_load_shows, advance && stage.valid, valid_reg, "loaded word not presented")
    `YRC_ASSERT_NEXT(a_stall_keeps, valid_reg && !ready, valid_reg && $stable(first_reg), "stalled word lost")

endmodule
